FILE: hdl/bccfc_pkg.sv
// Package for the BCC frame checker: frame constants, error codes,
// frame state and result structs. No dependencies.
package bccfc_pkg;

    localparam logic [7:0] HDR_BYTE0  = 8'hC5;
    localparam logic [7:0] HDR_BYTE1  = 8'h5C;
    localparam logic [7:0] TAIL_BYTE0 = 8'h5C;
    localparam logic [7:0] TAIL_BYTE1 = 8'hC5;

    localparam int POS_W = 17;
    localparam int LEN_W = 16;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_HEADER = 2'd1;
    localparam logic [1:0] ERR_BCC    = 2'd2;
    localparam logic [1:0] ERR_TAIL   = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             done;
        logic [7:0]       len_hi;
        logic [LEN_W-1:0] len;
        logic [7:0]       bcc;
        logic [1:0]       err;
        logic [7:0]       cmd;
        logic [7:0]       status;
    } frame_state_t;

    typedef struct packed {
        logic [1:0]       frame_error;
        logic [7:0]       command;
        logic [LEN_W-1:0] payload_length;
        logic [7:0]       ack_status;
    } frame_result_t;

endpackage

FILE: hdl/bccfc_frame_step.sv
// Next-state logic for one received byte of the BCC frame checker.
// Depends on bccfc_pkg.
module bccfc_frame_step
    import bccfc_pkg::*;
(
    input  frame_state_t  state_in,
    input  logic [7:0]    rx_byte,
    input  logic          chunk_start,
    output frame_state_t  state_out,
    output logic          result_valid,
    output frame_result_t result
);

    always_comb begin
        frame_state_t     cur;
        frame_state_t     nxt;
        logic [LEN_W-1:0] len_now;
        logic [POS_W-1:0] len_ext;
        logic [POS_W-1:0] p;

        cur = state_in;
        if (chunk_start) begin
            cur      = '0;
            cur.done = 1'b0;
        end
        nxt          = cur;
        result_valid = 1'b0;
        p            = cur.pos;

        // hi*255 as (hi<<8) - hi
        len_now = cur.len;
        if (p == POS_W'(4)) begin
            len_now = {cur.len_hi, 8'h00} - {8'h00, cur.len_hi} + {8'h00, rx_byte};
        end
        len_ext = {1'b0, len_now};

        if (!cur.done) begin
            if (p == POS_W'(2)) begin
                nxt.cmd = rx_byte;
            end
            if (p == POS_W'(3)) begin
                nxt.len_hi = rx_byte;
            end
            nxt.len = len_now;

            if (p == POS_W'(5) && nxt.cmd != 8'h00) begin
                nxt.status = rx_byte;
            end
            if (p >= POS_W'(4) && p == len_ext + POS_W'(4) && nxt.cmd == 8'h00) begin
                nxt.status = rx_byte;
            end

            if (p <= POS_W'(1)) begin
                if (rx_byte != ((p == '0) ? HDR_BYTE0 : HDR_BYTE1)) begin
                    nxt.err = ERR_HEADER;
                end
            end else if (p <= len_ext + POS_W'(4)) begin
                nxt.bcc = cur.bcc ^ rx_byte;
            end else if (p == len_ext + POS_W'(5)) begin
                if (cur.bcc != rx_byte) begin
                    nxt.err = ERR_BCC;
                end
            end else if (p == len_ext + POS_W'(6)) begin
                if (rx_byte != TAIL_BYTE0) begin
                    nxt.err = ERR_TAIL;
                end
            end else begin
                if (rx_byte != TAIL_BYTE1) begin
                    nxt.err = ERR_TAIL;
                end
                result_valid = 1'b1;
                nxt.done     = 1'b1;
            end
            nxt.pos = p + POS_W'(1);
        end

        state_out             = nxt;
        result.frame_error    = nxt.err;
        result.command        = nxt.cmd;
        result.payload_length = nxt.len;
        result.ack_status     = nxt.status;
    end

endmodule

FILE: hdl/bcc_frame_checker_core.sv
// Byte-serial checker for C5 5C framed packets with XOR block check.
// The request holding the last tail byte passes the input register, then the frame
// step, and its result is captured in the result register, which drives m_valid.
// Throughput: one byte per cycle; input register, one step of logic, result register.
// Input stalls only while a result waits with m_ready low.
// Reset (aresetn, synchronous, active low): idle, waiting for a chunk start;
// no result pending. Depends on bccfc_pkg and bccfc_frame_step.
module bcc_frame_checker_core
    import bccfc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_rx_byte,
    input  logic             s_chunk_start,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_frame_error,
    output logic [7:0]       m_command,
    output logic [LEN_W-1:0] m_payload_length,
    output logic [7:0]       m_ack_status
);

    // Input register stage
    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_start_reg;

    // Frame state and result register
    frame_state_t  state_reg;
    frame_state_t  state_next;
    frame_state_t  state_idle;
    logic          out_valid_reg;
    frame_result_t out_reg;

    logic          step_result_valid;
    frame_result_t step_result;
    logic          proc_fire;

    // Input request is processed when the result slot is free or being emptied.
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;

    bccfc_frame_step u_step (
        .state_in     (state_reg),
        .rx_byte      (in_byte_reg),
        .chunk_start  (in_start_reg),
        .state_out    (state_next),
        .result_valid (step_result_valid),
        .result       (step_result)
    );

    // Reset value of the frame state: all clear, done set.
    always_comb begin
        state_idle      = '0;
        state_idle.done = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg  <= s_rx_byte;
            in_start_reg <= s_chunk_start;
        end
    end

    // Frame state: reset leaves the checker idle until a chunk start.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= state_idle;
        end else if (proc_fire) begin
            state_reg <= state_next;
        end
    end

    // Result register; holds while the downstream stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire) begin
            out_valid_reg <= step_result_valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && step_result_valid) begin
            out_reg <= step_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_frame_error    = out_reg.frame_error;
    assign m_command        = out_reg.command;
    assign m_payload_length = out_reg.payload_length;
    assign m_ack_status     = out_reg.ack_status;

endmodule

FILE: hdl/bccfc_checker.sv
// Port-level assertions for the BCC frame checker, bound to the top level.
// Depends on bccfc_pkg and bcc_frame_checker_core.
module bccfc_checker
    import bccfc_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [1:0]       m_frame_error,
    input logic [7:0]       m_command,
    input logic [LEN_W-1:0] m_payload_length,
    input logic [7:0]       m_ack_status
);

    // Stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_error) && $stable(m_command)
            && $stable(m_payload_length) && $stable(m_ack_status))
        else $error("result changed while stalled");

    // No result straight out of reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Input is never back-pressured while the result slot is empty.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result slot");

    // A new result follows an accepted request through the input and result registers.
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without a preceding request");

endmodule

bind bcc_frame_checker_core bccfc_checker u_bccfc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_frame_error    (m_frame_error),
    .m_command        (m_command),
    .m_payload_length (m_payload_length),
    .m_ack_status     (m_ack_status)
);

FILE: tb/sv/bcc_frame_checker_core_tb.sv
// Self-checking bench for bcc_frame_checker_core: drives framed byte streams,
// predicts each frame result in a scoreboard class and checks every result.
// Depends on bccfc_pkg and the core RTL only.
`timescale 1ns / 100ps

typedef logic [7:0] octet_t;

// length field is hi*255+lo, not hi*256+lo
localparam logic [15:0] LEN_RADIX = 16'd255;
// ack command: status byte is taken from the end of the payload
localparam octet_t CMD_STATUS_AT_END = 8'h00;

class frame_check_board;
    // predicted checker state
    logic [bccfc_pkg::POS_W-1:0] pos     = '0;
    bit                          idle    = 1'b1;
    octet_t                      len_hi  = '0;
    logic [bccfc_pkg::LEN_W-1:0] plen    = '0;
    octet_t                      bcc     = '0;
    logic [1:0]                  err     = bccfc_pkg::ERR_NONE;
    octet_t                      cmd     = '0;
    octet_t                      status  = '0;
    bccfc_pkg::frame_result_t    expected_frames[$];
    int unsigned                 mismatches = 0;
    int unsigned                 checked    = 0;
    int unsigned                 by_error[4];

    // Returns 1 when the byte is part of a frame, 0 when the checker ignores it.
    function bit take_byte(octet_t data, logic restart);
        logic [bccfc_pkg::POS_W-1:0] last_data;
        bccfc_pkg::frame_result_t    res;
        if (restart) begin
            pos    = '0;
            idle   = 1'b0;
            len_hi = '0;
            plen   = '0;
            bcc    = '0;
            err    = bccfc_pkg::ERR_NONE;
            cmd    = '0;
            status = '0;
        end
        if (idle)
            return 1'b0;

        case (pos)
            2: cmd = data;
            3: len_hi = data;
            4: plen = len_hi * LEN_RADIX + data;
            default: ;
        endcase
        last_data = {1'b0, plen} + 17'd4;

        if (pos == 5 && cmd != CMD_STATUS_AT_END)
            status = data;
        if (pos >= 4 && pos == last_data && cmd == CMD_STATUS_AT_END)
            status = data;

        if (pos <= 1) begin
            if (data != ((pos == 0) ? bccfc_pkg::HDR_BYTE0 : bccfc_pkg::HDR_BYTE1))
                err = bccfc_pkg::ERR_HEADER;
        end else if (pos <= last_data) begin
            bcc ^= data;
        end else if (pos == last_data + 1) begin
            if (bcc != data)
                err = bccfc_pkg::ERR_BCC;
        end else if (pos == last_data + 2) begin
            if (data != bccfc_pkg::TAIL_BYTE0)
                err = bccfc_pkg::ERR_TAIL;
        end else begin
            if (data != bccfc_pkg::TAIL_BYTE1)
                err = bccfc_pkg::ERR_TAIL;
            res.frame_error    = err;
            res.command        = cmd;
            res.payload_length = plen;
            res.ack_status     = status;
            expected_frames.push_back(res);
            idle = 1'b1;
        end
        pos = pos + 17'd1;
        return 1'b1;
    endfunction

    function void check_frame(bccfc_pkg::frame_result_t got);
        bccfc_pkg::frame_result_t want;
        if (expected_frames.size() == 0) begin
            $error("result with none expected: error %0d cmd %02h len %0d status %02h",
                   got.frame_error, got.command, got.payload_length, got.ack_status);
            mismatches++;
            return;
        end
        want = expected_frames.pop_front();
        checked++;
        by_error[want.frame_error]++;
        if (got.frame_error !== want.frame_error) begin
            $error("frame_error: expected %0d, got %0d", want.frame_error, got.frame_error);
            mismatches++;
        end
        if (got.command !== want.command) begin
            $error("command: expected %02h, got %02h", want.command, got.command);
            mismatches++;
        end
        if (got.payload_length !== want.payload_length) begin
            $error("payload_length: expected %0d, got %0d",
                   want.payload_length, got.payload_length);
            mismatches++;
        end
        if (got.ack_status !== want.ack_status) begin
            $error("ack_status: expected %02h, got %02h", want.ack_status, got.ack_status);
            mismatches++;
        end
    endfunction
endclass

module bcc_frame_checker_core_tb
    import bccfc_pkg::*;
;

    localparam int unsigned ITEMS        = 1650;
    localparam int unsigned LONG_HOLD    = 400;     // output stall, cycles
    localparam int unsigned DRAIN_CYCLES = 16;      // plenty of margin to catch stray results
    localparam longint      LIMIT_NS     = 6_000_000;

    // fault injection bits for build_frame
    localparam int FLT_HDR0  = 0;
    localparam int FLT_HDR1  = 1;
    localparam int FLT_BCC   = 2;
    localparam int FLT_TAIL0 = 3;
    localparam int FLT_TAIL1 = 4;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [7:0]       s_rx_byte;
    logic             s_chunk_start;
    logic             m_valid;
    logic             m_ready;
    logic [1:0]       m_frame_error;
    logic [7:0]       m_command;
    logic [LEN_W-1:0] m_payload_length;
    logic [7:0]       m_ack_status;

    frame_check_board sb = new();
    int unsigned      taken        = 0;   // requests that reached a frame
    int unsigned      frames_tried = 0;

    bcc_frame_checker_core uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .s_chunk_start    (s_chunk_start),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_error    (m_frame_error),
        .m_command        (m_command),
        .m_payload_length (m_payload_length),
        .m_ack_status     (m_ack_status)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Idle length: mostly none, some short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic octet_t spoil(bit on);
        return on ? octet_t'($urandom_range(1, 255)) : 8'h00;
    endfunction

    // Whole frame with correct BCC and framing, then the requested bytes spoilt.
    function automatic void build_frame(ref octet_t q[$], input octet_t cmd,
                                        input octet_t hi, input octet_t lo,
                                        input logic [4:0] faults);
        octet_t      bcc;
        int unsigned n;
        q.delete();
        n = hi * LEN_RADIX + lo;
        q.push_back(HDR_BYTE0 ^ spoil(faults[FLT_HDR0]));
        q.push_back(HDR_BYTE1 ^ spoil(faults[FLT_HDR1]));
        q.push_back(cmd);
        q.push_back(hi);
        q.push_back(lo);
        bcc = cmd ^ hi ^ lo;
        repeat (n) begin
            q.push_back(octet_t'($urandom));
            bcc ^= q[$];
        end
        q.push_back(bcc ^ spoil(faults[FLT_BCC]));
        q.push_back(TAIL_BYTE0 ^ spoil(faults[FLT_TAIL0]));
        q.push_back(TAIL_BYTE1 ^ spoil(faults[FLT_TAIL1]));
    endfunction

    // One request: valid held with stable payload until the core takes it.
    // s_ready is sampled before this edge's updates land, so no race.
    task automatic send_byte(input octet_t data, input logic restart, input bit gapless);
        int unsigned gap;
        s_valid       <= 1'b1;
        s_rx_byte     <= data;
        s_chunk_start <= restart;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (sb.take_byte(data, restart))
            taken++;
        // valid only drops when a gap follows, so it is never lowered and
        // raised again within one step
        gap = gapless ? 0 : pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_seq(input octet_t q[$], input bit gapless);
        foreach (q[i])
            send_byte(q[i], i == 0, gapless);
        frames_tried++;
    endtask

    // Result monitor: outputs are sampled at the edge, ahead of any update.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_frame({m_frame_error, m_command, m_payload_length, m_ack_status});
    end

    // Result receiver: random stalls, runs of steady acceptance, and one long
    // hold-off once traffic is flowing so the core backs up into s_ready.
    initial begin : receiver
        int unsigned hold;
        int unsigned run;
        bit          held_long;
        held_long = 1'b0;
        m_ready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            if (!held_long && sb.checked >= 30) begin
                held_long = 1'b1;
                hold = LONG_HOLD;
            end else begin
                hold = pick_gap();
            end
            if (hold != 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
            repeat (run) @(posedge aclk);
        end
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $error("timed out with %0d results outstanding", sb.expected_frames.size());
        $display("bcc_frame_checker_core_tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        octet_t      q[$];
        logic [4:0]  fm;
        octet_t      cmd;
        octet_t      hi;
        octet_t      lo;
        int unsigned kind;
        int unsigned r;
        bit          gapless;

        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_rx_byte     <= 8'h00;
        s_chunk_start <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed cases ---
        // before any chunk start the core must swallow bytes silently
        send_byte(8'hA7, 1'b0, 1'b0);
        // smallest clean frame, ack command, zero length: status is the length low byte
        build_frame(q, CMD_STATUS_AT_END, 8'h00, 8'h00, '0);
        send_seq(q, 1'b0);
        // bad header and bad tail: tail code overrides; non-ack command with zero
        // length reports the BCC byte as status
        fm = '0;
        fm[FLT_HDR1]  = 1'b1;
        fm[FLT_TAIL1] = 1'b1;
        build_frame(q, 8'hFF, 8'h00, 8'h00, fm);
        send_seq(q, 1'b0);
        // frame abandoned after its header by the next chunk start: no result
        build_frame(q, 8'h01, 8'h00, 8'h00, '0);
        q = q[0:1];
        send_seq(q, 1'b0);
        // one payload byte, ack command, wrong BCC
        fm = '0;
        fm[FLT_BCC] = 1'b1;
        build_frame(q, CMD_STATUS_AT_END, 8'h00, 8'h01, fm);
        send_seq(q, 1'b0);
        // length with both bytes in use, sent back to back
        build_frame(q, CMD_STATUS_AT_END, 8'h01, 8'hFF, '0);
        send_seq(q, 1'b1);

        // --- random traffic ---
        // mostly complete frames with random content and occasional faults, some
        // cut short, some followed by stray bytes, plus bursts of line noise
        while (taken < ITEMS) begin
            kind    = $urandom_range(0, 99);
            gapless = ($urandom_range(0, 4) == 0);
            if (kind < 85) begin
                r = $urandom_range(0, 9);
                cmd = (r < 3) ? CMD_STATUS_AT_END : (r == 3) ? 8'hFF : octet_t'($urandom);
                if ($urandom_range(0, 29) == 0) begin
                    hi = 8'h01;
                    lo = octet_t'($urandom);
                end else begin
                    hi = 8'h00;
                    lo = ($urandom_range(0, 19) == 0) ? octet_t'($urandom)
                                                      : octet_t'($urandom_range(0, 24));
                end
                fm = '0;
                for (int i = 0; i < 5; i++)
                    if ($urandom_range(0, 99) < 7)
                        fm[i] = 1'b1;
                build_frame(q, cmd, hi, lo, fm);
                if (kind >= 70)
                    q = q[0:$urandom_range(0, q.size() - 2)];
                send_seq(q, gapless);
                // trailing junk after a finished frame is ignored by the core
                if (kind < 70 && $urandom_range(0, 6) == 0)
                    repeat ($urandom_range(1, 3))
                        send_byte(octet_t'($urandom), 1'b0, gapless);
            end else begin
                repeat ($urandom_range(1, 6))
                    send_byte(octet_t'($urandom), $urandom_range(0, 3) == 0, gapless);
            end
        end
        s_valid <= 1'b0;

        // drain: every predicted result must arrive, then watch for strays
        while (sb.expected_frames.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d framed requests over %0d frame attempts, incl. a %0d-byte payload",
                 taken, frames_tried, LEN_RADIX + 16'd255);
        $display("and a %0d-cycle output stall; results %0d (ok %0d, hdr %0d, bcc %0d, tail %0d)",
                 LONG_HOLD, sb.checked, sb.by_error[ERR_NONE], sb.by_error[ERR_HEADER],
                 sb.by_error[ERR_BCC], sb.by_error[ERR_TAIL]);
        if (sb.mismatches == 0) begin
            $display("bcc_frame_checker_core_tb: PASS");
        end else begin
            $display("bcc_frame_checker_core_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: bcc_frame_checker_core.f
hdl/bccfc_pkg.sv
hdl/bccfc_frame_step.sv
hdl/bcc_frame_checker_core.sv
hdl/bccfc_checker.sv
tb/sv/bcc_frame_checker_core_tb.sv
